/* hw/rtl/uvsph_pkg.sv */
// Shared types, constants and the arctangent table for the UV sphere vertex generator.
package uvsph_pkg;

  localparam int unsigned CountWidth       = 9;
  localparam int unsigned FieldWidth       = 16;
  localparam int unsigned PhaseWidth       = 32;
  localparam int unsigned CordicWidth      = 34;
  localparam int unsigned AtanEntries      = 24;
  localparam int unsigned MaxDivisionsDef  = 256;
  localparam int unsigned AngleItersDef    = 16;
  localparam int unsigned StackCountReset  = 48;
  localparam int unsigned SectorCountReset = 48;
  localparam logic [CordicWidth-1:0] CordicGain = CordicWidth'(652032874);
  localparam logic [PhaseWidth-1:0]  QuarterTurn = 32'h4000_0000;

  // Configuration register indexes.
  localparam logic [0:0] RegStackCount  = 1'b0;
  localparam logic [0:0] RegSectorCount = 1'b1;

  typedef logic [CountWidth-1:0] count_t;

  typedef struct packed {
    logic [CountWidth-1:0] stack_n;
    logic [CountWidth-1:0] sector_n;
  } counts_t;

  function automatic logic [PhaseWidth-1:0] atan_entry(input logic [4:0] k);
    logic [PhaseWidth-1:0] r;
    case (k)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2FA;
      5'd15:   r = 32'h0000517D;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A30;
      5'd19:   r = 32'h00000518;
      5'd20:   r = 32'h0000028C;
      5'd21:   r = 32'h00000146;
      5'd22:   r = 32'h000000A3;
      5'd23:   r = 32'h00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/uvsph_div.sv */
// Pipelined restoring divider: one quotient bit per stage, quotient truncated.
module uvsph_div #(
  parameter int unsigned NumW = 41,
  parameter int unsigned DenW = 9
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic [NumW-1:0] quo_o
);

  logic [NumW-1:0] rem_q [NumW+1];
  logic [NumW-1:0] quo_q [NumW+1];
  logic [DenW-1:0] den_q [NumW+1];

  always_comb begin
    rem_q[0] = num_i;
    quo_q[0] = '0;
    den_q[0] = den_i;
  end

  for (genvar s = 0; s < NumW; s++) begin : g_stage
    localparam int unsigned Bit = NumW - 1 - s;
    logic [NumW+DenW-1:0] sub_w;
    logic [NumW+DenW-1:0] rem_ext_w;
    logic                 ge_w;
    logic [NumW-1:0]      rem_d;
    logic [NumW-1:0]      quo_d;
    logic [NumW-1:0]      rem_r;
    logic [NumW-1:0]      quo_r;
    logic [DenW-1:0]      den_r;

    assign rem_ext_w = (NumW+DenW)'(rem_q[s]);
    assign sub_w     = (NumW+DenW)'(den_q[s]) << Bit;
    assign ge_w      = rem_ext_w >= sub_w;
    always_comb begin
      rem_d = rem_q[s];
      quo_d = quo_q[s];
      if (ge_w) begin
        rem_d = NumW'(rem_ext_w - sub_w);
        quo_d[Bit] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_r <= rem_d;
        quo_r <= quo_d;
        den_r <= den_q[s];
      end
    end
    always_comb begin
      rem_q[s+1] = rem_r;
      quo_q[s+1] = quo_r;
      den_q[s+1] = den_r;
    end
  end

  assign quo_o = quo_q[NumW];

endmodule

/* hw/rtl/uvsph_cordic.sv */
// Pipelined rotation-mode CORDIC giving cosine and sine in Q4.30 of a binary angle.
module uvsph_cordic #(
  parameter int unsigned Iters = uvsph_pkg::AngleItersDef
) (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic [uvsph_pkg::PhaseWidth-1:0]       phase_i,
  output logic signed [uvsph_pkg::CordicWidth-1:0] cos_o,
  output logic signed [uvsph_pkg::CordicWidth-1:0] sin_o
);

  localparam int unsigned W = uvsph_pkg::CordicWidth;
  localparam int unsigned Pw = uvsph_pkg::PhaseWidth;
  localparam int unsigned N = (Iters > uvsph_pkg::AtanEntries) ? uvsph_pkg::AtanEntries :
                              (Iters < 1) ? 1 : Iters;

  logic signed [W-1:0] x_s [N+1];
  logic signed [W-1:0] y_s [N+1];
  logic signed [W-1:0] z_s [N+1];
  logic [1:0]          q_s [N+1];

  logic [1:0]    q_w;
  logic [Pw-1:0] d_w;
  logic [Pw-1:0] ph_add_w;

  assign ph_add_w = phase_i + 32'h2000_0000;
  assign q_w      = ph_add_w[Pw-1:Pw-2];
  assign d_w      = phase_i - {q_w, {(Pw-2){1'b0}}};

  always_comb begin
    x_s[0] = signed'(uvsph_pkg::CordicGain);
    y_s[0] = '0;
    z_s[0] = W'(signed'(d_w));
    q_s[0] = q_w;
  end

  for (genvar k = 0; k < N; k++) begin : g_iter
    logic signed [W-1:0] x_r, y_r, z_r;
    logic [1:0]          q_r;
    logic signed [W-1:0] xs_w, ys_w, at_w;
    assign xs_w = x_s[k] >>> k;
    assign ys_w = y_s[k] >>> k;
    assign at_w = signed'(W'(uvsph_pkg::atan_entry(5'(k))));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_s[k][W-1]) begin
          x_r <= x_s[k] - ys_w;
          y_r <= y_s[k] + xs_w;
          z_r <= z_s[k] - at_w;
        end else begin
          x_r <= x_s[k] + ys_w;
          y_r <= y_s[k] - xs_w;
          z_r <= z_s[k] + at_w;
        end
        q_r <= q_s[k];
      end
    end
    always_comb begin
      x_s[k+1] = x_r;
      y_s[k+1] = y_r;
      z_s[k+1] = z_r;
      q_s[k+1] = q_r;
    end
  end

  always_comb begin
    case (q_s[N])
      2'd0: begin
        cos_o = x_s[N];
        sin_o = y_s[N];
      end
      2'd1: begin
        cos_o = -y_s[N];
        sin_o = x_s[N];
      end
      2'd2: begin
        cos_o = -x_s[N];
        sin_o = -y_s[N];
      end
      default: begin
        cos_o = y_s[N];
        sin_o = -x_s[N];
      end
    endcase
  end

endmodule

/* hw/rtl/uv_sphere_vertex_generator.sv */
// Top level of the UV sphere vertex generator: clamp, divide, CORDIC, multiply, output.
//
//  channel | signals                              | direction
//  in      | in_valid_i/in_ready_o, stack/sector  | beat in
//  out     | out_valid_o/out_ready_i, pos/tex     | beat out
//  cfg     | cfg_we_i, cfg_idx_i, cfg_data_i      | write only
//
// One beat per cycle sustained while the output is not stalled. Stages: the clamp
// register, 41 divider stages, ANGLE_ITERATIONS CORDIC stages, multiply, output.
// The whole pipeline advances only when the output register can take a beat;
// a stall freezes every stage. Reset clears the valid bits and sets both counts to 48.
module uv_sphere_vertex_generator #(
  parameter int unsigned MaxDivisions    = uvsph_pkg::MaxDivisionsDef,
  parameter int unsigned AngleIterations = uvsph_pkg::AngleItersDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [8:0]  stack_index_i,
  input  logic [8:0]  sector_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [15:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic signed [15:0] pos_z_o,
  output logic [15:0] tex_u_o,
  output logic [15:0] tex_v_o
);

  localparam int unsigned CW = uvsph_pkg::CountWidth;
  localparam int unsigned W  = uvsph_pkg::CordicWidth;
  localparam int unsigned NumW = CW + 32;
  localparam int unsigned Nit = (AngleIterations > uvsph_pkg::AtanEntries) ?
                                uvsph_pkg::AtanEntries : AngleIterations;
  localparam int unsigned MaxCnt = MaxDivisions;
  // Valid pipeline: clamp, divider, CORDIC, multiply, output.
  localparam int unsigned Depth = 1 + NumW + Nit + 2;

  logic [CW-1:0] stack_cnt_q, sector_cnt_q;
  logic          en_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_cnt_q  <= CW'(uvsph_pkg::StackCountReset);
      sector_cnt_q <= CW'(uvsph_pkg::SectorCountReset);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        uvsph_pkg::RegStackCount:  stack_cnt_q  <= cfg_data_i;
        uvsph_pkg::RegSectorCount: sector_cnt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  function automatic logic [CW-1:0] eff(input logic [CW-1:0] n);
    if (n == '0) return CW'(1);
    if (32'(n) > MaxCnt) return CW'(MaxCnt);
    return n;
  endfunction

  // Valid bits of every internal stage plus output register.
  logic [Depth-1:0] vld_q;
  assign en_w       = !out_valid_o || out_ready_i;
  assign in_ready_o = en_w;
  assign out_valid_o = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en_w) vld_q <= {vld_q[Depth-2:0], in_valid_i};
  end

  // Stage 0: clamp indices and form numerators.
  logic [CW-1:0] ns_q, nc_q, i_q, j_q;
  always_ff @(posedge clk_i) begin
    if (en_w) begin
      logic [CW-1:0] ns, nc;
      ns = eff(stack_cnt_q);
      nc = eff(sector_cnt_q);
      ns_q <= ns;
      nc_q <= nc;
      i_q  <= (stack_index_i > ns) ? ns : stack_index_i;
      j_q  <= (sector_index_i > nc) ? nc : sector_index_i;
    end
  end

  logic [NumW-1:0] sec_num_w, stk_num_w, sec_quo_w, stk_quo_w;
  assign sec_num_w = {j_q, 32'd0} + NumW'(nc_q >> 1);
  assign stk_num_w = {1'b0, i_q, 31'd0} + NumW'(ns_q >> 1);

  uvsph_div #(.NumW(NumW), .DenW(CW)) u_div_sec (
    .clk_i, .en_i(en_w), .num_i(sec_num_w), .den_i(nc_q), .quo_o(sec_quo_w)
  );
  uvsph_div #(.NumW(NumW), .DenW(CW)) u_div_stk (
    .clk_i, .en_i(en_w), .num_i(stk_num_w), .den_i(ns_q), .quo_o(stk_quo_w)
  );

  // Texture coordinates are not the top bits of the same quotients: j*2^32/n >> 17
  // rounded would differ, so they are divided alongside with their own rounding.
  logic [24:0] u_num_w, v_num_w, u_quo_w, v_quo_w;
  assign u_num_w = {1'b0, j_q, 15'd0} + 25'(nc_q >> 1);
  assign v_num_w = {1'b0, i_q, 15'd0} + 25'(ns_q >> 1);
  uvsph_div #(.NumW(25), .DenW(CW)) u_div_u (
    .clk_i, .en_i(en_w), .num_i(u_num_w), .den_i(nc_q), .quo_o(u_quo_w)
  );
  uvsph_div #(.NumW(25), .DenW(CW)) u_div_v (
    .clk_i, .en_i(en_w), .num_i(v_num_w), .den_i(ns_q), .quo_o(v_quo_w)
  );

  // Delay texture results to match the longer divider, the CORDIC and the multiply stage.
  localparam int unsigned TexDly = NumW - 25 + Nit + 1;
  logic [15:0] u_dly_q [TexDly];
  logic [15:0] v_dly_q [TexDly];
  always_ff @(posedge clk_i) begin
    if (en_w) begin
      u_dly_q[0] <= u_quo_w[15:0];
      v_dly_q[0] <= v_quo_w[15:0];
      for (int k = 1; k < TexDly; k++) begin
        u_dly_q[k] <= u_dly_q[k-1];
        v_dly_q[k] <= v_dly_q[k-1];
      end
    end
  end

  logic [31:0] ph_sec_w, ph_stk_w;
  assign ph_sec_w = sec_quo_w[31:0];
  assign ph_stk_w = uvsph_pkg::QuarterTurn - stk_quo_w[31:0];

  logic signed [W-1:0] cs_w, ss_w, cc_w, sc_w;
  uvsph_cordic #(.Iters(Nit)) u_cor_stk (
    .clk_i, .en_i(en_w), .phase_i(ph_stk_w), .cos_o(cs_w), .sin_o(ss_w)
  );
  uvsph_cordic #(.Iters(Nit)) u_cor_sec (
    .clk_i, .en_i(en_w), .phase_i(ph_sec_w), .cos_o(cc_w), .sin_o(sc_w)
  );

  // Multiply stage.
  logic signed [2*W-1:0] px_q, py_q;
  logic signed [W-1:0]   sz_q;
  always_ff @(posedge clk_i) begin
    if (en_w) begin
      px_q <= cs_w * cc_w;
      py_q <= cs_w * sc_w;
      sz_q <= ss_w;
    end
  end

  function automatic logic signed [15:0] sat16(input logic signed [2*W-1:0] v);
    if (v > (2*W)'(32767)) return 16'sd32767;
    if (v < -((2*W)'(32768))) return -16'sd32768;
    return v[15:0];
  endfunction

  logic signed [2*W-1:0] rx_w, ry_w, rz_w;
  assign rx_w = (px_q + (2*W)'(64'sd1 <<< 44)) >>> 45;
  assign ry_w = (py_q + (2*W)'(64'sd1 <<< 44)) >>> 45;
  assign rz_w = ((2*W)'(sz_q) + (2*W)'(16384)) >>> 15;

  always_ff @(posedge clk_i) begin
    if (en_w) begin
      pos_x_o <= sat16(rx_w);
      pos_y_o <= sat16(ry_w);
      pos_z_o <= sat16(rz_w);
      tex_u_o <= u_dly_q[TexDly-1];
      tex_v_o <= v_dly_q[TexDly-1];
    end
  end

endmodule

/* hw/rtl/uvsph_checker.sv */
// Port-level checker for the UV sphere vertex generator, bound to the top level.
module uvsph_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic signed [15:0] pos_z_o,
  input logic [15:0]       tex_u_o,
  input logic [15:0]       tex_v_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(tex_u_o) && $stable(pos_z_o))
    else $error("result changed while stalled");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while output register empty");

  a_tex_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> tex_u_o <= 16'd32768 && tex_v_o <= 16'd32768)
    else $error("texture coordinate above one");

endmodule

bind uv_sphere_vertex_generator uvsph_checker u_checker (.*);

/* dv/tb_uv_sphere_vertex_generator.sv */
// Testbench for the UV sphere vertex generator: directed table, random grid points, scoreboard.
`timescale 1ns / 1ps

module tb_uv_sphere_vertex_generator;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
  } vertex_t;

  typedef struct {
    logic [8:0]         stack_idx;
    logic [8:0]         sector_idx;
    bit                 pin_z;
    bit                 pin_uv;
    logic signed [15:0] z;
    logic [15:0]        u;
    logic [15:0]        v;
  } grid_row_t;

  localparam int unsigned NumIters = uvsph_pkg::AngleItersDef;
  localparam logic [31:0] AtanTurns [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [8:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [8:0]  stack_index_i;
  logic [8:0]  sector_index_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic signed [15:0] pos_x_o;
  logic signed [15:0] pos_y_o;
  logic signed [15:0] pos_z_o;
  logic [15:0] tex_u_o;
  logic [15:0] tex_v_o;

  uv_sphere_vertex_generator i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .stack_index_i  (stack_index_i),
    .sector_index_i (sector_index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .pos_z_o        (pos_z_o),
    .tex_u_o        (tex_u_o),
    .tex_v_o        (tex_v_o)
  );

  vertex_t     pending_vertices [$];
  logic [8:0]  stack_reg;
  logic [8:0]  sector_reg;
  int unsigned mismatches;
  int unsigned vertices_seen;
  int unsigned burst_left;
  int unsigned hold_left;
  int unsigned ready_mode;
  bit          hold_done;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic longint unsigned eff_count(input logic [8:0] r);
    if (r == 0) return 1;
    if (r > uvsph_pkg::MaxDivisionsDef) return uvsph_pkg::MaxDivisionsDef;
    return longint'(r);
  endfunction

  function automatic logic signed [15:0] sat16(input longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Rotation-mode CORDIC on the residual after folding the phase into a quadrant.
  task automatic sin_cos(input logic [31:0] phase, output longint co, output longint si);
    logic [31:0] quad;
    logic [31:0] resid;
    longint x, y, z, xs, ys;
    quad = ((phase + 32'h2000_0000) >> 30) & 32'd3;
    resid = phase - (quad << 30);
    z = longint'($signed(resid));
    x = 652032874;
    y = 0;
    for (int k = 0; k < NumIters; k++) begin
      xs = x >>> k;
      ys = y >>> k;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - longint'(AtanTurns[k]);
      end else begin
        x = x + ys; y = y - xs; z = z + longint'(AtanTurns[k]);
      end
    end
    case (quad)
      32'd0:   begin co = x;  si = y;  end
      32'd1:   begin co = -y; si = x;  end
      32'd2:   begin co = -x; si = -y; end
      default: begin co = y;  si = -x; end
    endcase
  endtask

  task automatic grid_vertex(input logic [8:0] si_in, input logic [8:0] sj_in,
                             output vertex_t vtx);
    longint unsigned ns, nc, ii, jj, q;
    logic [31:0] ph_sec, ph_stk;
    longint cs, ss, cc, sc, half;
    ns = eff_count(stack_reg);
    nc = eff_count(sector_reg);
    ii = (si_in > ns) ? ns : longint'(si_in);
    jj = (sj_in > nc) ? nc : longint'(sj_in);
    q = ((jj << 32) + nc / 2) / nc;
    ph_sec = q[31:0];
    q = ((ii << 31) + ns / 2) / ns;
    ph_stk = uvsph_pkg::QuarterTurn - q[31:0];
    sin_cos(ph_stk, cs, ss);
    sin_cos(ph_sec, cc, sc);
    half = longint'(1) << 44;
    vtx.pos_x = sat16((cs * cc + half) >>> 45);
    vtx.pos_y = sat16((cs * sc + half) >>> 45);
    vtx.pos_z = sat16((ss + (longint'(1) << 14)) >>> 15);
    q = ((jj << 15) + nc / 2) / nc;
    vtx.tex_u = q[15:0];
    q = ((ii << 15) + ns / 2) / ns;
    vtx.tex_v = q[15:0];
  endtask

  task automatic write_reg(input logic idx, input logic [8:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == uvsph_pkg::RegStackCount) stack_reg = data;
    else sector_reg = data;
  endtask

  task automatic drain;
    while (pending_vertices.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic send_point(input grid_row_t row);
    vertex_t vtx;
    if (burst_left == 0) begin
      if (in_valid_i) in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    stack_index_i  <= row.stack_idx;
    sector_index_i <= row.sector_idx;
    do @(posedge clk_i); while (!in_ready_o);
    grid_vertex(row.stack_idx, row.sector_idx, vtx);
    if (row.pin_z) vtx.pos_z = row.z;
    if (row.pin_uv) begin
      vtx.tex_u = row.u;
      vtx.tex_v = row.v;
    end
    pending_vertices = {pending_vertices, vtx};
  endtask

  task automatic random_points(input int unsigned n);
    grid_row_t row;
    int unsigned ns, nc;
    ns = 32'(eff_count(stack_reg));
    nc = 32'(eff_count(sector_reg));
    row.pin_z = 0;
    row.pin_uv = 0;
    for (int unsigned k = 0; k < n; k++) begin
      // Mostly points on the grid; the rest anywhere from 0 to 256.
      if ($urandom_range(0, 4) != 0) begin
        row.stack_idx  = 9'($urandom_range(0, ns));
        row.sector_idx = 9'($urandom_range(0, nc));
      end else begin
        row.stack_idx  = 9'($urandom_range(0, 256));
        row.sector_idx = 9'($urandom_range(0, 256));
      end
      send_point(row);
    end
  endtask

  always @(posedge clk_i) begin
    vertex_t got, want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = '{pos_x_o, pos_y_o, pos_z_o, tex_u_o, tex_v_o};
        vertices_seen++;
        if (pending_vertices.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected vertex beat %p", got);
        end else begin
          want = pending_vertices.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp x%0d y%0d z%0d u%0d v%0d, got x%0d y%0d z%0d u%0d v%0d",
                       want.pos_x, want.pos_y, want.pos_z, want.tex_u, want.tex_v,
                       got.pos_x, got.pos_y, got.pos_z, got.tex_u, got.tex_v);
          end
        end
      end
      if (!hold_done && vertices_seen == 200) begin
        hold_done = 1;
        hold_left = 400;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if ($urandom_range(0, 63) == 0) ready_mode = $urandom_range(0, 2);
        case (ready_mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= ($urandom_range(0, 3) != 0);
          default: out_ready_i <= ($urandom_range(0, 1) != 0);
        endcase
      end
    end
  end

  initial begin
    grid_row_t rows [14];
    logic [8:0] settings [6][2];
    cfg_we_i = 0; cfg_idx_i = 0; cfg_data_i = 0;
    in_valid_i = 0; stack_index_i = 0; sector_index_i = 0;
    out_ready_i = 0;
    stack_reg = 9'(uvsph_pkg::StackCountReset);
    sector_reg = 9'(uvsph_pkg::SectorCountReset);
    mismatches = 0; vertices_seen = 0; burst_left = 0;
    hold_left = 0; hold_done = 0; ready_mode = 0;
    rst_ni = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset counts of 48; poles, equator, clamping and the wrapped last sector.
    rows = '{
      '{9'd0,   9'd0,   1, 1, 16'sh7FFF, 16'd0,     16'd0},
      '{9'd48,  9'd0,   1, 1, 16'sh8000, 16'd0,     16'd32768},
      '{9'd256, 9'd256, 1, 1, 16'sh8000, 16'd32768, 16'd32768},
      '{9'd24,  9'd24,  0, 1, 16'sh0,    16'd16384, 16'd16384},
      '{9'd24,  9'd48,  0, 1, 16'sh0,    16'd32768, 16'd16384},
      '{9'd12,  9'd12,  0, 1, 16'sh0,    16'd8192,  16'd8192},
      '{9'd1,   9'd47,  0, 0, 16'sh0,    16'd0,     16'd0},
      '{9'd47,  9'd1,   0, 0, 16'sh0,    16'd0,     16'd0},
      '{9'd255, 9'd0,   0, 0, 16'sh0,    16'd0,     16'd0},
      '{9'd0,   9'd255, 0, 0, 16'sh0,    16'd0,     16'd0},
      '{9'd6,   9'd36,  0, 0, 16'sh0,    16'd0,     16'd0},
      '{9'd30,  9'd18,  0, 0, 16'sh0,    16'd0,     16'd0},
      '{9'd100, 9'd3,   0, 0, 16'sh0,    16'd0,     16'd0},
      '{9'd5,   9'd49,  0, 0, 16'sh0,    16'd0,     16'd0}
    };
    foreach (rows[r]) send_point(rows[r]);
    random_points(300);

    settings = '{'{9'd1, 9'd1}, '{9'd256, 9'd256}, '{9'd0, 9'd0},
                 '{9'd511, 9'd300}, '{9'd3, 9'd7}, '{9'd0, 9'd0}};
    settings[5][0] = 9'($urandom_range(1, 511));
    settings[5][1] = 9'($urandom_range(1, 511));
    foreach (settings[p]) begin
      in_valid_i <= 1'b0;
      burst_left = 0;
      drain();
      write_reg(uvsph_pkg::RegStackCount, settings[p][0]);
      write_reg(uvsph_pkg::RegSectorCount, settings[p][1]);
      random_points(120);
    end
    in_valid_i <= 1'b0;

    while (pending_vertices.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && pending_vertices.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/uvsph_pkg.sv
hw/rtl/uvsph_div.sv
hw/rtl/uvsph_cordic.sv
hw/rtl/uv_sphere_vertex_generator.sv
hw/rtl/uvsph_checker.sv
dv/tb_uv_sphere_vertex_generator.sv
